FILE: hdl/pis_pkg.sv
// ----------------------------------------------------------------------------
// pis_pkg
// shared types, constants and saturating fixed-point helpers
// ----------------------------------------------------------------------------
package pis_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int AW        = 5;

    localparam logic [AW-1:0] ADDR_MODE = AW'(0);
    localparam logic [AW-1:0] ADDR_T    = AW'(4);
    localparam logic [AW-1:0] ADDR_G    = AW'(8);
    localparam logic [AW-1:0] ADDR_D    = AW'(12);
    localparam logic [AW-1:0] ADDR_CX   = AW'(16);
    localparam logic [AW-1:0] ADDR_CY   = AW'(20);

    localparam logic [30:0] RST_T = 31'd655;
    localparam logic [30:0] RST_G = 31'd65536;

    typedef logic signed [DW-1:0] t_fx;

    typedef struct packed {
        t_fx  v;
        logic s;
    } t_sat;

    function automatic t_sat clamp_wide(input logic signed [65:0] x);
        t_sat r;
        if (x > 66'sd2147483647) begin
            r.v = 32'sh7fffffff;
            r.s = 1'b1;
        end else if (x < -66'sd2147483648) begin
            r.v = 32'sh80000000;
            r.s = 1'b1;
        end else begin
            r.v = x[DW-1:0];
            r.s = 1'b0;
        end
        return r;
    endfunction

    function automatic t_sat sadd(input t_fx a, input t_fx b);
        logic signed [65:0] x;
        x = 66'(a) + 66'(b);
        return clamp_wide(x);
    endfunction

    function automatic t_sat ssub(input t_fx a, input t_fx b);
        logic signed [65:0] x;
        x = 66'(a) - 66'(b);
        return clamp_wide(x);
    endfunction

    // operands are 33-bit signed so that -2^31 and 2^31-1 fit
    function automatic t_sat smul(input logic signed [32:0] a,
                                  input logic signed [32:0] b,
                                  input logic half);
        logic signed [65:0] p;
        logic signed [65:0] q;
        p = 66'(a) * 66'(b);
        if (half) begin
            q = (p + (66'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
        end else begin
            q = (p + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        end
        return clamp_wide(q);
    endfunction

endpackage

FILE: hdl/particle_integration_step.sv
// ----------------------------------------------------------------------------
// particle_integration_step
// one euler or velocity-verlet step of a 2d particle with damping
// ----------------------------------------------------------------------------
// channel   | handshake          | payload
// ----------+--------------------+-----------------------------------------
// input     | i_start / o_busy   | i_pos_*, i_vel_*, i_acc_*, i_last_particle
// result    | o_done strobe      | o_new_*, o_frame_end, o_saturated
// config    | apb psel/penable   | paddr, pwdata, prdata
//
// one word enters per cycle; the step is a chain of dependent multiplies
// and adds, each stage followed by a register.
// reset clears the valid bits and loads register defaults.
// o_busy is always low: the pipeline never stalls.
module particle_integration_step (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic signed [31:0]      i_pos_x,
    input  logic signed [31:0]      i_pos_y,
    input  logic signed [31:0]      i_vel_x,
    input  logic signed [31:0]      i_vel_y,
    input  logic signed [31:0]      i_acc_x,
    input  logic signed [31:0]      i_acc_y,
    input  logic                    i_last_particle,
    output logic                    o_done,
    output logic signed [31:0]      o_new_pos_x,
    output logic signed [31:0]      o_new_pos_y,
    output logic signed [31:0]      o_new_vel_x,
    output logic signed [31:0]      o_new_vel_y,
    output logic signed [31:0]      o_new_acc_x,
    output logic signed [31:0]      o_new_acc_y,
    output logic                    o_frame_end,
    output logic                    o_saturated,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [pis_pkg::AW-1:0]  paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import pis_pkg::*;

    localparam int NS = 13;

    logic        r_mode;
    logic [30:0] r_t, r_g, r_d;
    t_fx         r_cx, r_cy;

    assign pready = 1'b1;
    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
            r_t    <= RST_T;
            r_g    <= RST_G;
            r_d    <= '0;
            r_cx   <= '0;
            r_cy   <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                ADDR_MODE: r_mode <= pwdata[0];
                ADDR_T:    r_t    <= pwdata[30:0];
                ADDR_G:    r_g    <= pwdata[30:0];
                ADDR_D:    r_d    <= pwdata[30:0];
                ADDR_CX:   r_cx   <= pwdata;
                ADDR_CY:   r_cy   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_MODE: prdata = {31'd0, r_mode};
            ADDR_T:    prdata = {1'b0, r_t};
            ADDR_G:    prdata = {1'b0, r_g};
            ADDR_D:    prdata = {1'b0, r_d};
            ADDR_CX:   prdata = r_cx;
            ADDR_CY:   prdata = r_cy;
            default:   prdata = '0;
        endcase
    end

    logic signed [32:0] w_t, w_ng, w_nd;
    assign w_t  = $signed({2'b00, r_t});
    assign w_ng = -$signed({2'b00, r_g});
    assign w_nd = -$signed({2'b00, r_d});

    // per-lane pipeline state
    typedef struct packed {
        t_fx p, v, a, x, y, z, u, f;
        logic s;
    } t_lane;

    t_lane r_l [NS][2];
    logic  r_vld [NS];
    logic  r_last [NS];
    logic  r_m [NS];
    t_fx   r_q;
    logic  r_qs;

    // coefficient q = 0.5*t*t computed in stage 0 alongside
    t_sat w_q;
    assign w_q = smul(w_t, w_t, 1'b1);

    t_lane n_l [NS][2];

    always_comb begin
        t_sat a1, a2, a3;
        t_fx  pin [2], vin [2], ain [2], cc [2];
        pin[0] = i_pos_x; pin[1] = i_pos_y;
        vin[0] = i_vel_x; vin[1] = i_vel_y;
        ain[0] = i_acc_x; ain[1] = i_acc_y;
        cc[0]  = r_cx;    cc[1]  = r_cy;
        for (int k = 0; k < 2; k++) begin
            // stage 0: x = mul(t,v), y = mul(t,a)
            n_l[0][k] = '0;
            n_l[0][k].p = pin[k]; n_l[0][k].v = vin[k]; n_l[0][k].a = ain[k];
            a1 = smul(w_t, 33'(vin[k]), 1'b0);
            a2 = smul(w_t, 33'(ain[k]), 1'b0);
            n_l[0][k].x = a1.v; n_l[0][k].y = a2.v; n_l[0][k].s = a1.s | a2.s;
            // stage 1: p1 = p + x (euler p'); u = v + y; z = mul(q,a)
            n_l[1][k] = r_l[0][k];
            a1 = sadd(r_l[0][k].p, r_l[0][k].x);
            a2 = sadd(r_l[0][k].v, r_l[0][k].y);
            a3 = smul(33'(r_q), 33'(r_l[0][k].a), 1'b0);
            n_l[1][k].p = a1.v; n_l[1][k].u = a2.v; n_l[1][k].z = a3.v;
            n_l[1][k].s = r_l[0][k].s | a1.s | a2.s | (r_m[0] & (a3.s | r_qs));
            // stage 2: np = p1 + z (verlet); euler keeps p1; x = sub(np,c)
            n_l[2][k] = r_l[1][k];
            a1 = sadd(r_l[1][k].p, r_l[1][k].z);
            if (r_m[1]) n_l[2][k].p = a1.v;
            a2 = ssub(n_l[2][k].p, cc[k]);
            n_l[2][k].x = a2.v;
            n_l[2][k].s = r_l[1][k].s | (r_m[1] & a1.s) | a2.s;
            // stage 3: f = mul(-g, x); z = damp(u)
            n_l[3][k] = r_l[2][k];
            a1 = smul(w_ng, 33'(r_l[2][k].x), 1'b0);
            a2 = smul(w_nd, 33'(r_l[2][k].u), 1'b0);
            n_l[3][k].f = a1.v; n_l[3][k].z = a2.v;
            n_l[3][k].s = r_l[2][k].s | a1.s | a2.s;
            // stage 4: euler: na = z + f, nv = u ; verlet: x = (f + z) - a
            n_l[4][k] = r_l[3][k];
            if (r_m[3]) begin
                a1 = sadd(r_l[3][k].f, r_l[3][k].z);
                a2 = ssub(a1.v, r_l[3][k].a);
                n_l[4][k].x = a2.v;
                n_l[4][k].s = r_l[3][k].s | a1.s | a2.s;
            end else begin
                a1 = sadd(r_l[3][k].z, r_l[3][k].f);
                n_l[4][k].f = a1.v;
                n_l[4][k].v = r_l[3][k].u;
                n_l[4][k].s = r_l[3][k].s | a1.s;
            end
            // stage 5: y = hmul(t, x)
            n_l[5][k] = r_l[4][k];
            a1 = smul(w_t, 33'(r_l[4][k].x), 1'b1);
            n_l[5][k].y = a1.v;
            n_l[5][k].s = r_l[4][k].s | (r_m[4] & a1.s);
            // stage 6: u = u + y
            n_l[6][k] = r_l[5][k];
            a1 = sadd(r_l[5][k].u, r_l[5][k].y);
            if (r_m[5]) n_l[6][k].u = a1.v;
            n_l[6][k].s = r_l[5][k].s | (r_m[5] & a1.s);
            // stage 7: z = damp(u)
            n_l[7][k] = r_l[6][k];
            a1 = smul(w_nd, 33'(r_l[6][k].u), 1'b0);
            n_l[7][k].z = a1.v;
            n_l[7][k].s = r_l[6][k].s | (r_m[6] & a1.s);
            // stage 8: x = (a + f) + z
            n_l[8][k] = r_l[7][k];
            a1 = sadd(r_l[7][k].a, r_l[7][k].f);
            a2 = sadd(a1.v, r_l[7][k].z);
            n_l[8][k].x = a2.v;
            n_l[8][k].s = r_l[7][k].s | (r_m[7] & (a1.s | a2.s));
            // stage 9: y = hmul(t, x)
            n_l[9][k] = r_l[8][k];
            a1 = smul(w_t, 33'(r_l[8][k].x), 1'b1);
            n_l[9][k].y = a1.v;
            n_l[9][k].s = r_l[8][k].s | (r_m[8] & a1.s);
            // stage 10: nv = v + y
            n_l[10][k] = r_l[9][k];
            a1 = sadd(r_l[9][k].v, r_l[9][k].y);
            if (r_m[9]) n_l[10][k].v = a1.v;
            n_l[10][k].s = r_l[9][k].s | (r_m[9] & a1.s);
            // stage 11: z = damp(nv)
            n_l[11][k] = r_l[10][k];
            a1 = smul(w_nd, 33'(r_l[10][k].v), 1'b0);
            n_l[11][k].z = a1.v;
            n_l[11][k].s = r_l[10][k].s | (r_m[10] & a1.s);
            // stage 12: na = f + z
            n_l[12][k] = r_l[11][k];
            a1 = sadd(r_l[11][k].f, r_l[11][k].z);
            if (r_m[11]) n_l[12][k].f = a1.v;
            n_l[12][k].s = r_l[11][k].s | (r_m[11] & a1.s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) r_vld[i] <= 1'b0;
        end else begin
            r_vld[0] <= i_start;
            for (int i = 1; i < NS; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_last[0] <= i_last_particle;
        r_m[0]    <= r_mode;
        r_q       <= w_q.v;
        r_qs      <= w_q.s;
        for (int i = 1; i < NS; i++) begin
            r_last[i] <= r_last[i-1];
            r_m[i]    <= r_m[i-1];
        end
        for (int i = 0; i < NS; i++) begin
            r_l[i][0] <= n_l[i][0];
            r_l[i][1] <= n_l[i][1];
        end
    end

    assign o_done      = r_vld[NS-1];
    assign o_new_pos_x = r_l[NS-1][0].p;
    assign o_new_pos_y = r_l[NS-1][1].p;
    assign o_new_vel_x = r_l[NS-1][0].v;
    assign o_new_vel_y = r_l[NS-1][1].v;
    assign o_new_acc_x = r_l[NS-1][0].f;
    assign o_new_acc_y = r_l[NS-1][1].f;
    assign o_frame_end = r_last[NS-1];
    assign o_saturated = r_l[NS-1][0].s | r_l[NS-1][1].s;

endmodule

FILE: hdl/pis_checker.sv
// ----------------------------------------------------------------------------
// pis_checker
// port-level checks of the integration step
// ----------------------------------------------------------------------------
module pis_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_done,
    input logic pready
);
    a_ready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
    a_nobusy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##13 o_done)
        else $error("word lost");
    a_noinv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 13))
        else $error("word invented");
endmodule

bind particle_integration_step pis_checker u_pis_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
    .o_busy(o_busy), .o_done(o_done), .pready(pready)
);

FILE: sim/particle_integration_step_test.sv
// ----------------------------------------------------------------------------
// particle_integration_step_test
// self-checking bench for the particle integration step: euler and verlet
// words are sent through start/busy, each result word is predicted in
// saturating fixed point and compared field by field on the done strobe
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_integration_step_test;
    import pis_pkg::*;

    localparam int LATENCY = 13;
    localparam int RAND_ITEMS = 1650;

    typedef struct {
        logic signed [31:0] px, py, vx, vy, ax, ay;
        logic               last;
    } t_particle;

    typedef struct {
        logic signed [31:0] px, py, vx, vy, ax, ay;
        logic               fe, sat;
    } t_step;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_vel_x = '0;
    logic signed [31:0] i_vel_y = '0, i_acc_x = '0, i_acc_y = '0;
    logic i_last_particle = 1'b0;
    logic o_done;
    logic signed [31:0] o_new_pos_x, o_new_pos_y, o_new_vel_x;
    logic signed [31:0] o_new_vel_y, o_new_acc_x, o_new_acc_y;
    logic o_frame_end, o_saturated;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    particle_integration_step dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor copy of the registers
    logic        m_mode = 1'b1;
    longint      m_t = 655, m_g = 65536, m_d = 0, m_cx = 0, m_cy = 0;
    bit          clamp_hit;
    int          idle_pct = 0;
    int          errors = 0, words_sent = 0, words_checked = 0;
    t_step       expected_steps[$];

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) begin
            clamp_hit = 1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            clamp_hit = 1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic longint fxmul(longint a, longint b, int sh);
        longint p;
        p = a * b + (64'sd1 <<< (sh - 1));
        return sat32(p >>> sh);
    endfunction

    function automatic longint fm(longint a, longint b);
        return fxmul(a, b, FRAC_BITS);
    endfunction

    function automatic longint hm(longint a, longint b);
        return fxmul(a, b, FRAC_BITS + 1);
    endfunction

    function automatic longint ad(longint a, longint b);
        return sat32(a + b);
    endfunction

    function automatic t_step predict_step(t_particle w);
        t_step r;
        longint p[2], v[2], a[2], c[2], np[2], nv[2], na[2];
        longint q, f, u;
        p[0] = w.px; p[1] = w.py; v[0] = w.vx; v[1] = w.vy;
        a[0] = w.ax; a[1] = w.ay; c[0] = m_cx; c[1] = m_cy;
        clamp_hit = 0;
        // the coefficient only exists in verlet mode
        q = 0;
        if (m_mode) q = hm(m_t, m_t);
        for (int k = 0; k < 2; k++) begin
            if (!m_mode) begin
                np[k] = ad(p[k], fm(m_t, v[k]));
                nv[k] = ad(v[k], fm(m_t, a[k]));
                na[k] = ad(fm(-m_d, nv[k]), fm(-m_g, sat32(np[k] - c[k])));
            end else begin
                np[k] = ad(ad(p[k], fm(m_t, v[k])), fm(q, a[k]));
                f = fm(-m_g, sat32(np[k] - c[k]));
                u = ad(v[k], fm(m_t, a[k]));
                u = ad(u, hm(m_t, sat32(ad(f, fm(-m_d, u)) - a[k])));
                nv[k] = ad(v[k], hm(m_t, ad(ad(a[k], f), fm(-m_d, u))));
                na[k] = ad(f, fm(-m_d, nv[k]));
            end
        end
        r.px = 32'(np[0]); r.py = 32'(np[1]); r.vx = 32'(nv[0]); r.vy = 32'(nv[1]);
        r.ax = 32'(na[0]); r.ay = 32'(na[1]); r.fe = w.last; r.sat = clamp_hit;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch word %0d %s: got %0d want %0d", words_checked, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_steps.size() == 0) begin
                errors++;
                $display("unexpected result word");
            end else begin
                t_step e;
                e = expected_steps.pop_front();
                if (o_new_pos_x !== e.px) report_mismatch("pos_x", o_new_pos_x, e.px);
                if (o_new_pos_y !== e.py) report_mismatch("pos_y", o_new_pos_y, e.py);
                if (o_new_vel_x !== e.vx) report_mismatch("vel_x", o_new_vel_x, e.vx);
                if (o_new_vel_y !== e.vy) report_mismatch("vel_y", o_new_vel_y, e.vy);
                if (o_new_acc_x !== e.ax) report_mismatch("acc_x", o_new_acc_x, e.ax);
                if (o_new_acc_y !== e.ay) report_mismatch("acc_y", o_new_acc_y, e.ay);
                if (o_frame_end !== e.fe) report_mismatch("frame_end", o_frame_end, e.fe);
                if (o_saturated !== e.sat) report_mismatch("saturated", o_saturated, e.sat);
                words_checked++;
            end
        end
    end

    task automatic apb_write(logic [AW-1:0] addr, logic [31:0] data);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (addr)
            ADDR_MODE: m_mode = data[0];
            ADDR_T:    m_t = data[30:0];
            ADDR_G:    m_g = data[30:0];
            ADDR_D:    m_d = data[30:0];
            ADDR_CX:   m_cx = longint'($signed(data));
            ADDR_CY:   m_cy = longint'($signed(data));
            default: ;
        endcase
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        while (expected_steps.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic configure(logic mode, logic [31:0] t, logic [31:0] g,
                             logic [31:0] d, logic [31:0] cx, logic [31:0] cy);
        drain_results();
        apb_write(ADDR_MODE, {31'd0, mode});
        apb_write(ADDR_T, t);
        apb_write(ADDR_G, g);
        apb_write(ADDR_D, d);
        apb_write(ADDR_CX, cx);
        apb_write(ADDR_CY, cy);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_word(t_particle w);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_pos_x <= w.px; i_pos_y <= w.py; i_vel_x <= w.vx; i_vel_y <= w.vy;
        i_acc_x <= w.ax; i_acc_y <= w.ay; i_last_particle <= w.last;
        do @(posedge i_clk); while (o_busy);
        expected_steps.push_back(predict_step(w));
        words_sent++;
    endtask

    function automatic logic [31:0] rand_fx(int kind);
        case (kind)
            0: return $urandom();
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            default: return {{16{1'($urandom_range(1))}}, 16'($urandom())};
        endcase
    endfunction

    function automatic t_particle rand_particle();
        t_particle w;
        int k;
        k = $urandom_range(9) == 0 ? 0 : $urandom_range(1, 3);
        w.px = rand_fx(k); w.py = rand_fx(k); w.vx = rand_fx(k);
        w.vy = rand_fx(k); w.ax = rand_fx(k); w.ay = rand_fx(k);
        w.last = $urandom_range(7) == 0;
        return w;
    endfunction

    task automatic test_directed();
        logic signed [31:0] ext[4] = '{32'sh7fffffff, 32'sh80000000, 0, -1};
        t_particle w;
        idle_pct = 0;
        for (int m = 0; m < 2; m++) begin
            configure(m[0], 32'd655, 32'd65536, 32'd0, 32'd0, 32'd0);
            for (int i = 0; i < 4; i++) begin
                w.px = ext[i]; w.py = ext[3-i]; w.vx = ext[(i+1)%4];
                w.vy = ext[(i+2)%4]; w.ax = ext[(i+3)%4]; w.ay = ext[i];
                w.last = i[0];
                send_word(w);
            end
        end
        configure(1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h8000_0000, 32'h7fff_ffff);
        for (int i = 0; i < 4; i++) send_word(rand_particle());
        configure(1'b0, 32'h7fffffff, 0, 32'h7fffffff, 32'h7fff_ffff, 32'h8000_0000);
        for (int i = 0; i < 4; i++) send_word(rand_particle());
        configure(1'b1, 0, 0, 0, 0, 0);
        for (int i = 0; i < 4; i++) send_word(rand_particle());
    endtask

    task automatic test_random();
        int pct[4] = '{0, 79, 0, 27};
        for (int ph = 0; ph < 8; ph++) begin
            configure(ph[0], $urandom_range(0, 32'h0002_0000),
                      $urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0002_0000),
                      rand_fx($urandom_range(1, 2)), rand_fx($urandom_range(1, 2)));
            if (ph == 7) configure(1'b1, $urandom(), $urandom(), $urandom(),
                                   $urandom(), $urandom());
            idle_pct = pct[ph % 4];
            for (int i = 0; i < RAND_ITEMS / 8; i++) begin
                if (i == 100) drain_results();
                send_word(rand_particle());
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        drain_results();
        $display("sent %0d particle words, checked %0d results", words_sent, words_checked);
        $display("both integrators, extreme and random registers, idle phases");
        if (errors == 0 && expected_steps.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
